@@ design/tmcv_pkg.sv @@
// Shared constants, codes and types for the text-mode character video core.
// Used by every module of the core and by its checker; depends on nothing.
package tmcv_pkg;

    // Text geometry
    localparam int TEXT_COLS   = 64;
    localparam int TEXT_ROWS   = 28;
    localparam int CELL_WIDTH  = 6;
    localparam int CELL_HEIGHT = 10;
    localparam int GLYPH_LINES = 8;

    localparam int TEXT_W = TEXT_COLS * CELL_WIDTH;
    localparam int TEXT_H = TEXT_ROWS * CELL_HEIGHT;

    // Border frame: text area offset and extra size
    localparam int BORDER_X       = 1;
    localparam int BORDER_Y       = 3;
    localparam int BORDER_EXTRA_W = 33;
    localparam int BORDER_EXTRA_H = 8;

    // Memories
    localparam int VRAM_DEPTH = 2048;
    localparam int GRAM_DEPTH = 1024;
    localparam int VADDR_W    = $clog2(VRAM_DEPTH);
    localparam int GADDR_W    = $clog2(GRAM_DEPTH);

    // Field widths
    localparam int FUNC_W = 2;
    localparam int ADDR_W = 11;
    localparam int DATA_W = 8;
    localparam int POS_W  = 9;

    // Text counter widths
    localparam int PX_W   = $clog2(CELL_WIDTH);
    localparam int COL_W  = $clog2(TEXT_COLS);
    localparam int LINE_W = $clog2(CELL_HEIGHT);
    localparam int ROW_W  = $clog2(TEXT_ROWS);

    // Character byte fields
    localparam logic [DATA_W-1:0] CHAR_MASK     = 8'h7f;
    localparam int                UNDERLINE_BIT = 7;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_VRAM_WR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GRAM_WR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Pixel information that travels with a tick
    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              frame_end;
        logic              in_text;
        logic [LINE_W-1:0] line;
        logic [PX_W-1:0]   px;
        logic              col_last;
    } meta_t;

    // One classified request
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [VADDR_W-1:0] cell_idx;
        meta_t              meta;
    } item_t;

endpackage

@@ design/tmcv_front.sv @@
// Front part: raster tracking and classification of incoming requests.
// Depends on tmcv_pkg; feeds tmcv_queue.
module tmcv_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr,
    input  logic                         cfg_border,
    input  logic                         accept,
    input  logic [tmcv_pkg::FUNC_W-1:0]  func,
    input  logic [tmcv_pkg::ADDR_W-1:0]  addr,
    input  logic [tmcv_pkg::DATA_W-1:0]  data,
    output logic                         push,
    output tmcv_pkg::item_t              item
);

    logic                           border_reg;
    logic [tmcv_pkg::POS_W-1:0]     x_reg, x_next;
    logic [tmcv_pkg::POS_W-1:0]     y_reg, y_next;
    logic [tmcv_pkg::PX_W-1:0]      px_reg, px_next;
    logic [tmcv_pkg::COL_W-1:0]     col_reg, col_next;
    logic [tmcv_pkg::LINE_W-1:0]    line_reg, line_next;
    logic [tmcv_pkg::ROW_W-1:0]     row_reg, row_next;

    logic [tmcv_pkg::POS_W:0]       x_lo, x_hi, y_lo, y_hi;
    logic [tmcv_pkg::POS_W-1:0]     w_last, h_last;
    logic                           x_in, y_in, last_x, last_y, tick;

    always_comb
    begin
        x_lo   = border_reg ? (tmcv_pkg::POS_W+1)'(tmcv_pkg::BORDER_X) : '0;
        y_lo   = border_reg ? (tmcv_pkg::POS_W+1)'(tmcv_pkg::BORDER_Y) : '0;
        x_hi   = x_lo + (tmcv_pkg::POS_W+1)'(tmcv_pkg::TEXT_W);
        y_hi   = y_lo + (tmcv_pkg::POS_W+1)'(tmcv_pkg::TEXT_H);
        w_last = border_reg ?
                 tmcv_pkg::POS_W'(tmcv_pkg::TEXT_W + tmcv_pkg::BORDER_EXTRA_W - 1) :
                 tmcv_pkg::POS_W'(tmcv_pkg::TEXT_W - 1);
        h_last = border_reg ?
                 tmcv_pkg::POS_W'(tmcv_pkg::TEXT_H + tmcv_pkg::BORDER_EXTRA_H - 1) :
                 tmcv_pkg::POS_W'(tmcv_pkg::TEXT_H - 1);
        x_in   = ({1'b0, x_reg} >= x_lo) && ({1'b0, x_reg} < x_hi);
        y_in   = ({1'b0, y_reg} >= y_lo) && ({1'b0, y_reg} < y_hi);
        last_x = (x_reg == w_last);
        last_y = (y_reg == h_last);
        tick   = accept && (func == tmcv_pkg::FUNC_TICK);
    end

    // Raster advance after each tick
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        px_next   = px_reg;
        col_next  = col_reg;
        line_next = line_reg;
        row_next  = row_reg;
        if (tick)
        begin
            if (last_x)
            begin
                x_next   = '0;
                px_next  = '0;
                col_next = '0;
                if (last_y)
                begin
                    y_next    = '0;
                    line_next = '0;
                    row_next  = '0;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                    if (y_in)
                    begin
                        if (line_reg == tmcv_pkg::LINE_W'(tmcv_pkg::CELL_HEIGHT - 1))
                        begin
                            line_next = '0;
                            row_next  = row_reg + 1'b1;
                        end
                        else
                        begin
                            line_next = line_reg + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                x_next = x_reg + 1'b1;
                if (x_in)
                begin
                    if (px_reg == tmcv_pkg::PX_W'(tmcv_pkg::CELL_WIDTH - 1))
                    begin
                        px_next  = '0;
                        col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        px_next = px_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            px_reg     <= '0;
            col_reg    <= '0;
            line_reg   <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            // restart the raster on a mode change
            border_reg <= cfg_border;
            x_reg      <= '0;
            y_reg      <= '0;
            px_reg     <= '0;
            col_reg    <= '0;
            line_reg   <= '0;
            row_reg    <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            px_reg   <= px_next;
            col_reg  <= col_next;
            line_reg <= line_next;
            row_reg  <= row_next;
        end
    end

    // Drop the unused function code here
    assign push = accept && (func != tmcv_pkg::FUNC_NONE);

    always_comb
    begin
        item.func           = func;
        item.addr           = addr;
        item.data           = data;
        item.cell_idx       = tmcv_pkg::VADDR_W'(32'(row_reg) * tmcv_pkg::TEXT_COLS
                                                 + 32'(col_reg));
        item.meta.pos_x     = x_reg;
        item.meta.pos_y     = y_reg;
        item.meta.frame_end = last_x && last_y;
        item.meta.in_text   = x_in && y_in;
        item.meta.line      = line_reg;
        item.meta.px        = px_reg;
        item.meta.col_last  = (col_reg == tmcv_pkg::COL_W'(tmcv_pkg::TEXT_COLS - 1));
    end

endmodule

@@ design/tmcv_queue.sv @@
// Short FIFO of classified requests between front and back.
// Depends on tmcv_pkg.
module tmcv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tmcv_pkg::item_t  push_item,
    input  logic             pop,
    output tmcv_pkg::item_t  head,
    output logic             empty,
    output logic             full
);

    tmcv_pkg::item_t                slot_reg [tmcv_pkg::Q_DEPTH];
    logic [tmcv_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [tmcv_pkg::Q_CNT_W-1:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == tmcv_pkg::Q_CNT_W'(tmcv_pkg::Q_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/tmcv_back.sv @@
// Back part: video and glyph memories, clearing pass, pixel pipeline and
// output register. Depends on tmcv_pkg; drains tmcv_queue.
module tmcv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tmcv_pkg::item_t             head,
    input  logic                        empty,
    output logic                        pop,
    output logic                        clearing,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pixel_lit,
    output logic [tmcv_pkg::POS_W-1:0]  pos_x,
    output logic [tmcv_pkg::POS_W-1:0]  pos_y,
    output logic                        frame_end
);

    logic [tmcv_pkg::DATA_W-1:0]   vram [tmcv_pkg::VRAM_DEPTH];
    logic [tmcv_pkg::DATA_W-1:0]   gram [tmcv_pkg::GRAM_DEPTH];

    logic                          clearing_reg;
    logic [tmcv_pkg::VADDR_W-1:0]  clr_reg;

    logic                          en;
    logic                          s1_valid_reg, s2_valid_reg, out_valid_reg;
    tmcv_pkg::meta_t               s1_meta_reg, s2_meta_reg;
    logic [tmcv_pkg::DATA_W-1:0]   vchar_reg, vnext_reg, glyph_reg;
    logic                          uline_reg;
    logic                          lit_reg, frame_end_reg;
    logic [tmcv_pkg::POS_W-1:0]    pos_x_reg, pos_y_reg;

    logic [tmcv_pkg::VADDR_W-1:0]  cell_next_addr;
    logic [tmcv_pkg::GADDR_W-1:0]  gaddr;
    logic                          glyph_line, lit_next;

    assign en       = !out_valid_reg || !out_stall;
    assign pop      = en && !empty && !clearing_reg;
    assign clearing = clearing_reg;

    // Clear both memories after reset, one address a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == tmcv_pkg::VADDR_W'(tmcv_pkg::VRAM_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    // Stage 1: memory writes and video reads of this cell and the next
    assign cell_next_addr = head.cell_idx + 1'b1;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            vram[clr_reg] <= '0;
        else if (pop && head.func == tmcv_pkg::FUNC_VRAM_WR)
            vram[head.addr[tmcv_pkg::VADDR_W-1:0]] <= head.data;
        if (en)
        begin
            vchar_reg <= vram[head.cell_idx];
            vnext_reg <= vram[cell_next_addr];
        end
    end

    // Stage 2: glyph read
    assign gaddr = tmcv_pkg::GADDR_W'(32'(vchar_reg & tmcv_pkg::CHAR_MASK)
                                      * tmcv_pkg::GLYPH_LINES
                                      + 32'(s1_meta_reg.line));

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            gram[clr_reg[tmcv_pkg::GADDR_W-1:0]] <= '0;
        else if (pop && head.func == tmcv_pkg::FUNC_GRAM_WR)
            gram[head.addr[tmcv_pkg::GADDR_W-1:0]] <= head.data;
        if (en)
            glyph_reg <= gram[gaddr];
    end

    // Payload registers of the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_meta_reg   <= head.meta;
            s2_meta_reg   <= s1_meta_reg;
            uline_reg     <= (32'(s1_meta_reg.line) == 32'(tmcv_pkg::GLYPH_LINES))
                             && !s1_meta_reg.col_last
                             && vnext_reg[tmcv_pkg::UNDERLINE_BIT];
            lit_reg       <= lit_next;
            pos_x_reg     <= s2_meta_reg.pos_x;
            pos_y_reg     <= s2_meta_reg.pos_y;
            frame_end_reg <= s2_meta_reg.frame_end;
        end
    end

    // Stage 3: pick the glyph bit, bit 5 for the leftmost pixel of the cell; a clear bit is lit
    assign glyph_line = 32'(s2_meta_reg.line) < 32'(tmcv_pkg::GLYPH_LINES);

    always_comb
    begin
        if (!s2_meta_reg.in_text)
            lit_next = 1'b0;
        else if (glyph_line)
            lit_next = !glyph_reg[3'(tmcv_pkg::CELL_WIDTH - 1) - 3'(s2_meta_reg.px)];
        else
            lit_next = uline_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pop && (head.func == tmcv_pkg::FUNC_TICK);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_lit = lit_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign frame_end = frame_end_reg;

endmodule

@@ design/text_mode_character_video_core.sv @@
// Top level of the text-mode character video core (64x28 cells of 6x10).
// Depends on tmcv_pkg, tmcv_front, tmcv_queue and tmcv_back.
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  in        sink       in_valid / in_stall  func, addr, data
//  out       source     out_valid/out_stall  pixel_lit, pos_x, pos_y, frame_end
//  cfg       sink       cfg_valid/cfg_ready  cfg_data (border_on)
//
// One request a cycle is taken in steady state, while in_stall is low. A tick
// taken into an empty queue leaves it together with the video read, then passes
// the glyph read and the output register before its pixel shows; earlier
// requests still waiting in the queue go ahead of it.
// After reset both memories are zeroed; in_stall stays high until the clearing
// pass ends, and configuration writes are taken all the while.
// Output stalls freeze the back pipeline; the four-entry queue absorbs
// requests until it fills, then in_stall rises.
module text_mode_character_video_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tmcv_pkg::FUNC_W-1:0] func,
    input  logic [tmcv_pkg::ADDR_W-1:0] addr,
    input  logic [tmcv_pkg::DATA_W-1:0] data,
    // pixel channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pixel_lit,
    output logic [tmcv_pkg::POS_W-1:0]  pos_x,
    output logic [tmcv_pkg::POS_W-1:0]  pos_y,
    output logic                        frame_end,
    // configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);

    logic             accept;
    logic             cfg_wr;
    logic             push, pop, q_empty, q_full, clearing;
    tmcv_pkg::item_t  push_item, head;

    // Hold requests while the queue is full or the memories are still clearing
    assign in_stall  = q_full || clearing;
    assign accept    = in_valid && !in_stall;

    // Always take the mode register; the user must write it only when the core is idle (not enforced here)
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Front: track the raster and classify each request
    tmcv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .cfg_border (cfg_data),
        .accept     (accept),
        .func       (func),
        .addr       (addr),
        .data       (data),
        .push       (push),
        .item       (push_item)
    );

    // Queue: decouple request intake from memory work
    tmcv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: apply writes in order, render ticks into pixels
    tmcv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_lit (pixel_lit),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .frame_end (frame_end)
    );

endmodule

@@ design/tmcv_checker.sv @@
// Port-level checker for the text-mode character video core, bound to the top.
// Depends on tmcv_pkg and text_mode_character_video_core.
module tmcv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        pixel_lit,
    input logic [tmcv_pkg::POS_W-1:0]  pos_x,
    input logic [tmcv_pkg::POS_W-1:0]  pos_y,
    input logic                        frame_end
);

    // Stalled pixel holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_lit) && $stable(pos_x)
                                   && $stable(pos_y) && $stable(frame_end))
        else $error("stalled pixel changed");

    // Frame end only at one of the two frame corners
    a_frame_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |->
            (pos_x == 9'd383 && pos_y == 9'd279) || (pos_x == 9'd416 && pos_y == 9'd287))
        else $error("frame end away from frame corner");

    // Right and bottom border stay dark
    a_border_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pos_x > 9'd384 || pos_y > 9'd282) |-> !pixel_lit)
        else $error("lit pixel outside text area");

    // Memory clearing holds off requests right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall && !out_valid)
        else $error("requests taken before memories cleared");

endmodule

bind text_mode_character_video_core tmcv_checker u_tmcv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_lit (pixel_lit),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .frame_end (frame_end)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for text_mode_character_video_core: random and directed requests
// in both border modes. Depends on tmcv_pkg and the core's RTL only.

typedef struct packed {
    logic                       lit;
    logic [tmcv_pkg::POS_W-1:0] x;
    logic [tmcv_pkg::POS_W-1:0] y;
    logic                       frame_end;
} pixel_t;

// Shadow of the core: both memories, the raster and the border bit; one pixel per tick.
class raster_scoreboard;
    logic [tmcv_pkg::DATA_W-1:0] video_ram [tmcv_pkg::VRAM_DEPTH];
    logic [tmcv_pkg::DATA_W-1:0] glyph_ram [tmcv_pkg::GRAM_DEPTH];
    int unsigned                 raster_x;
    int unsigned                 raster_y;
    bit                          border_on;
    pixel_t                      expected_pixels [$];
    int unsigned                 mismatches;

    function new();
        foreach (video_ram[i]) video_ram[i] = '0;
        foreach (glyph_ram[i]) glyph_ram[i] = '0;
        raster_x   = 0;
        raster_y   = 0;
        border_on  = 1'b0;
        mismatches = 0;
    endfunction

    function void restart(bit b);
        border_on = b;
        raster_x  = 0;
        raster_y  = 0;
    endfunction

    function int unsigned frame_width();
        return border_on ? tmcv_pkg::TEXT_W + tmcv_pkg::BORDER_EXTRA_W : tmcv_pkg::TEXT_W;
    endfunction

    function int unsigned frame_height();
        return border_on ? tmcv_pkg::TEXT_H + tmcv_pkg::BORDER_EXTRA_H : tmcv_pkg::TEXT_H;
    endfunction

    function int unsigned pending();
        return expected_pixels.size();
    endfunction

    // Cell index and cell line under the raster; cell 0 when outside the text area.
    function int unsigned cell_under_raster(output int unsigned line);
        int unsigned ox;
        int unsigned oy;
        ox = border_on ? tmcv_pkg::BORDER_X : 0;
        oy = border_on ? tmcv_pkg::BORDER_Y : 0;
        line = 0;
        if (raster_x < ox || raster_y < oy ||
            raster_x - ox >= tmcv_pkg::TEXT_W || raster_y - oy >= tmcv_pkg::TEXT_H)
            return 0;
        line = (raster_y - oy) % tmcv_pkg::CELL_HEIGHT;
        return ((raster_y - oy) / tmcv_pkg::CELL_HEIGHT) * tmcv_pkg::TEXT_COLS
               + (raster_x - ox) / tmcv_pkg::CELL_WIDTH;
    endfunction

    function bit shade_at(int unsigned x, int unsigned y);
        int unsigned ox, oy, tx, ty, col, px, row, line, cell_idx;
        logic [tmcv_pkg::DATA_W-1:0] ch;
        logic [tmcv_pkg::DATA_W-1:0] g;
        ox = border_on ? tmcv_pkg::BORDER_X : 0;
        oy = border_on ? tmcv_pkg::BORDER_Y : 0;
        if (x < ox || y < oy)
            return 1'b0;
        tx = x - ox;
        ty = y - oy;
        if (tx >= tmcv_pkg::TEXT_W || ty >= tmcv_pkg::TEXT_H)
            return 1'b0;
        col      = tx / tmcv_pkg::CELL_WIDTH;
        px       = tx % tmcv_pkg::CELL_WIDTH;
        row      = ty / tmcv_pkg::CELL_HEIGHT;
        line     = ty % tmcv_pkg::CELL_HEIGHT;
        cell_idx = row * tmcv_pkg::TEXT_COLS + col;
        if (line < tmcv_pkg::GLYPH_LINES)
        begin
            ch = video_ram[cell_idx % tmcv_pkg::VRAM_DEPTH] & tmcv_pkg::CHAR_MASK;
            g  = glyph_ram[(ch * tmcv_pkg::GLYPH_LINES + line) % tmcv_pkg::GRAM_DEPTH];
            return !g[tmcv_pkg::CELL_WIDTH - 1 - px];
        end
        if (line == tmcv_pkg::GLYPH_LINES && col != tmcv_pkg::TEXT_COLS - 1 &&
            video_ram[(cell_idx + 1) % tmcv_pkg::VRAM_DEPTH][tmcv_pkg::UNDERLINE_BIT])
            return 1'b1;
        return 1'b0;
    endfunction

    function void note_request(logic [tmcv_pkg::FUNC_W-1:0] f,
                               logic [tmcv_pkg::ADDR_W-1:0] a,
                               logic [tmcv_pkg::DATA_W-1:0] d);
        pixel_t e;
        case (f)
            tmcv_pkg::FUNC_VRAM_WR: video_ram[a] = d;
            tmcv_pkg::FUNC_GRAM_WR: glyph_ram[a[tmcv_pkg::GADDR_W-1:0]] = d;
            tmcv_pkg::FUNC_TICK:
            begin
                e.lit       = shade_at(raster_x, raster_y);
                e.x         = raster_x[tmcv_pkg::POS_W-1:0];
                e.y         = raster_y[tmcv_pkg::POS_W-1:0];
                e.frame_end = (raster_x == frame_width() - 1) &&
                              (raster_y == frame_height() - 1);
                expected_pixels.push_back(e);
                raster_x++;
                if (raster_x >= frame_width())
                begin
                    raster_x = 0;
                    raster_y++;
                    if (raster_y >= frame_height())
                        raster_y = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_pixel(logic lit, logic [tmcv_pkg::POS_W-1:0] x,
                              logic [tmcv_pkg::POS_W-1:0] y, logic frame_end);
        pixel_t e;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel: lit=%0b x=%0d y=%0d end=%0b", lit, x, y, frame_end);
            return;
        end
        e = expected_pixels.pop_front();
        if (lit !== e.lit || x !== e.x || y !== e.y || frame_end !== e.frame_end)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"pixel mismatch: expected lit=%0b x=%0d y=%0d end=%0b, ",
                          "got lit=%0b x=%0d y=%0d end=%0b"},
                         e.lit, e.x, e.y, e.frame_end, lit, x, y, frame_end);
        end
    endfunction
endclass

module tb;
    // Cycles to let the queue and the back pipeline empty out once the last
    // pixel is in: four queued requests, three pipeline stages, a stall burst.
    localparam int DRAIN_CYCLES = 32;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [tmcv_pkg::FUNC_W-1:0] func      = tmcv_pkg::FUNC_VRAM_WR;
    logic [tmcv_pkg::ADDR_W-1:0] addr      = '0;
    logic [tmcv_pkg::DATA_W-1:0] data      = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        pixel_lit;
    logic [tmcv_pkg::POS_W-1:0]  pos_x;
    logic [tmcv_pkg::POS_W-1:0]  pos_y;
    logic                        frame_end;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_data  = 1'b0;

    // Percent chance of an idle burst, shared by the request and pixel sides.
    int unsigned                 idle_pct  = 0;

    raster_scoreboard            sb = new();

    text_mode_character_video_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .addr      (addr),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_lit (pixel_lit),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold the pixel channel off in random bursts and release it between bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every pixel taken at this edge; the values read here are the
    // ones from before the edge, so no ordering within the step matters.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_pixel(pixel_lit, pos_x, pos_y, frame_end);
    end

    // Present one request, maybe after an idle burst, and hold it until taken.
    task automatic send_request(input logic [tmcv_pkg::FUNC_W-1:0] f,
                                input logic [tmcv_pkg::ADDR_W-1:0] a,
                                input logic [tmcv_pkg::DATA_W-1:0] d);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        addr     <= a;
        data     <= d;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(f, a, d);
    endtask

    // Mostly ticks; writes aim at the cells just ahead of the raster and at
    // the glyph line of the character under it, so that they show up in the
    // pixels soon after. A quarter of the writes go anywhere.
    task automatic send_random(input int unsigned tick_pct,
                               output logic [tmcv_pkg::FUNC_W-1:0] f);
        int unsigned                 line;
        int unsigned                 cell_idx;
        int unsigned                 gl;
        logic [tmcv_pkg::DATA_W-1:0] ch;
        logic [tmcv_pkg::ADDR_W-1:0] a;
        cell_idx = sb.cell_under_raster(line);
        a        = tmcv_pkg::ADDR_W'($urandom);
        if ($urandom_range(0, 99) < tick_pct)
            f = tmcv_pkg::FUNC_TICK;
        else
            case ($urandom_range(0, 9))
                0: f = tmcv_pkg::FUNC_NONE;
                1, 2, 3, 4:
                begin
                    f = tmcv_pkg::FUNC_VRAM_WR;
                    if ($urandom_range(0, 3) != 0)
                        a = tmcv_pkg::ADDR_W'(cell_idx + $urandom_range(0, 40));
                end
                default:
                begin
                    f  = tmcv_pkg::FUNC_GRAM_WR;
                    ch = sb.video_ram[cell_idx] & tmcv_pkg::CHAR_MASK;
                    gl = (line < tmcv_pkg::GLYPH_LINES) ? line
                         : $urandom_range(0, tmcv_pkg::GLYPH_LINES - 1);
                    // top address bit is random: the glyph RAM must drop it
                    if ($urandom_range(0, 3) != 0)
                        a = {1'($urandom), ch[6:0], 3'(gl)};
                end
            endcase
        send_request(f, a, tmcv_pkg::DATA_W'($urandom));
    endtask

    // Random requests; switch the idling on and off every hundred or so.
    task automatic run_random(input int unsigned items, input int unsigned tick_pct);
        int unsigned                 counted;
        logic [tmcv_pkg::FUNC_W-1:0] f;
        counted = 0;
        while (counted < items)
        begin
            if (counted % 100 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            send_random(tick_pct, f);
            if (f != tmcv_pkg::FUNC_NONE)
                counted++;
        end
    endtask

    // Back-to-back ticks with writes mixed in, no idling on either side.
    task automatic run_steady(input int unsigned target);
        int unsigned                 ticks;
        logic [tmcv_pkg::FUNC_W-1:0] f;
        idle_pct = 0;
        ticks    = 0;
        while (ticks < target)
        begin
            send_random(88, f);
            if (f == tmcv_pkg::FUNC_TICK)
                ticks++;
        end
    endtask

    // Drop the request valid, wait for the last pixel, then let the queued
    // writes drain through.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the border bit; the core restarts its raster on any write.
    task automatic write_border(input bit b);
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.restart(b);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The register is taken during the memory clear; requests wait it out.
        write_border(1'b0);

        // Directed: blank memories give lit pixels, then a few glyph and cell writes
        // around the first cells, address aliasing and an unused code.
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_GRAM_WR, 11'h000, 8'h2A);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_VRAM_WR, 11'h000, 8'hFF);
        send_request(tmcv_pkg::FUNC_GRAM_WR, 11'h7F8, 8'hFF);
        send_request(tmcv_pkg::FUNC_VRAM_WR, 11'h001, 8'h80);
        send_request(tmcv_pkg::FUNC_NONE,    11'h7FF, 8'hFF);
        send_request(tmcv_pkg::FUNC_VRAM_WR, 11'h7FF, 8'h5A);
        send_request(tmcv_pkg::FUNC_GRAM_WR, 11'h400, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_GRAM_WR, 11'h3FF, 8'hC0);
        send_request(tmcv_pkg::FUNC_TICK,    11'h7FF, 8'hFF);
        send_request(tmcv_pkg::FUNC_TICK,    11'h000, 8'h00);

        run_random(550, 50);

        // Border mode mid-frame: the raster must restart at the corner.
        settle();
        write_border(1'b1);
        send_request(tmcv_pkg::FUNC_TICK, 11'h000, 8'h00);
        send_request(tmcv_pkg::FUNC_TICK, 11'h7FF, 8'hFF);
        run_random(550, 70);

        // Last part: steady ticks in both modes, no idling on either side.
        settle();
        write_border(1'b0);
        run_steady(60);
        settle();
        write_border(1'b1);
        run_steady(60);
        settle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        #15000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
